// ===== hw/rtl/cmg_pkg.sv =====
// Shared constants for the coalition majority grid block.
package cmg_pkg;

    localparam int SIDE_DEF     = 256;
    localparam int TIE_BITS_DEF = 32;

    // Fixed port field widths
    localparam int IDX_W     = 16;
    localparam int OP_W      = 2;
    localparam int CNT_W     = 17;
    localparam int TIE_OUT_W = 32;

    // Opinion codes
    localparam logic [OP_W-1:0] OP_C = 2'd0;
    localparam logic [OP_W-1:0] OP_A = 2'd1;
    localparam logic [OP_W-1:0] OP_B = 2'd2;

    // Action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

endpackage

// ===== hw/rtl/cmg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cmg_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/coalition_majority_grid_update.sv =====
// Majority-rule opinion grid (A/B coalition against C) on a toroidal SIDE x SIDE grid.
//
// Input channel (i_in_valid / o_in_ready) carries one transaction per item: a load
// writes one cell's opinion, an update applies the majority rule at a cell and its
// four wrap-around neighbours. Output channel (o_out_valid / i_out_ready) returns
// one transaction per item with the three opinion totals, the saturating tie count
// and the settled flag as they stand after that item.
// An ignored item (index out of range, or a load of opinion code 3) goes straight
// to the output register. A load reads and rewrites its one cell; an update splits
// the index into row and column by a reciprocal multiply (S_MUL, then S_ADDR),
// reads its five cells one per cycle, decides, and writes all five back one per
// cycle only when it rewrites them. Items are worked one at a time; o_in_ready
// rises again in the cycle after the result is placed in the output register.
// The grid RAM has one write port and one read port.
// After reset the block sweeps all SIDE*SIDE cells to C, one cell a cycle, with
// o_in_ready low. A stalled receiver holds the result in the output register; one
// further item may be worked meanwhile and then waits for it.
module coalition_majority_grid_update #(
    parameter int SIDE     = cmg_pkg::SIDE_DEF,
    parameter int TIE_BITS = cmg_pkg::TIE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [cmg_pkg::IDX_W-1:0]     i_cell_index,
    input  logic [cmg_pkg::OP_W-1:0]      i_opinion,
    input  logic                          i_tie_choice,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cmg_pkg::CNT_W-1:0]     o_count_a,
    output logic [cmg_pkg::CNT_W-1:0]     o_count_b,
    output logic [cmg_pkg::CNT_W-1:0]     o_count_c,
    output logic [cmg_pkg::TIE_OUT_W-1:0] o_tie_count,
    output logic                          o_settled
);

    import cmg_pkg::*;

    localparam int CELLS = SIDE * SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int TW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(SIDE);
    localparam int SH    = IDX_W + RW;
    localparam int MW    = IDX_W + 2;
    localparam int PW    = AW + MW;
    localparam longint RECIP = ((longint'(1) << SH) + longint'(SIDE) - 1) / longint'(SIDE);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ADDR,
        S_RD,
        S_LAST,
        S_DECIDE,
        S_WR,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_clr;
    logic                r_action;
    logic [AW-1:0]       r_k;
    logic [OP_W-1:0]     r_opinion;
    logic                r_pick;
    logic [PW-1:0]       r_prod;
    logic [RW-1:0]       r_row;
    logic [RW-1:0]       r_col;
    logic [2:0]          r_idx;
    logic [2:0]          r_last;
    logic                r_pend;
    logic [2:0]          r_na;
    logic [2:0]          r_nb;
    logic [2:0]          r_nc;
    logic [OP_W-1:0]     r_fill_op;
    logic [TW-1:0]       r_tot_a;
    logic [TW-1:0]       r_tot_b;
    logic [TW-1:0]       r_tot_c;
    logic [TIE_BITS-1:0] r_ties;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_out_a;
    logic [CNT_W-1:0]    r_out_b;
    logic [CNT_W-1:0]    r_out_c;
    logic [TIE_OUT_W-1:0] r_out_ties;
    logic                r_out_settled;

    logic [AW-1:0]   c_cells [5];
    logic [RW-1:0]   c_row;
    logic            c_accept;
    logic            c_in_range;
    logic            c_write;
    logic            c_tie_inc;
    logic [OP_W-1:0] c_fill_op;
    logic [3:0]      c_ab;
    logic [TW-1:0]   c_nfill;
    logic            c_out_free;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [OP_W-1:0] ram_wdata;
    logic [OP_W-1:0] ram_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign c_accept   = i_in_valid && o_in_ready;
    assign c_in_range = (32'(i_cell_index) < CELLS);
    assign c_out_free = !r_out_valid || i_out_ready;
    assign c_row      = RW'(r_prod >> SH);
    assign c_nfill    = TW'(r_last) + TW'(1);

    // Centre, up, right, down, left, each wrapping round the torus
    always_comb begin
        c_cells[0] = r_k;
        c_cells[1] = (r_row == '0) ? r_k + AW'(CELLS - SIDE) : r_k - AW'(SIDE);
        c_cells[2] = (r_col == RW'(SIDE - 1)) ? r_k - AW'(SIDE - 1) : r_k + AW'(1);
        c_cells[3] = (r_row == RW'(SIDE - 1)) ? r_k - AW'(CELLS - SIDE) : r_k + AW'(SIDE);
        c_cells[4] = (r_col == '0) ? r_k + AW'(SIDE - 1) : r_k - AW'(1);
    end

    // Majority decision over the gathered counts
    always_comb begin
        c_write   = 1'b0;
        c_tie_inc = 1'b0;
        c_fill_op = OP_C;
        c_ab      = 4'(r_na) + 4'(r_nb);
        if (r_action == ACT_LOAD) begin
            c_write   = 1'b1;
            c_fill_op = r_opinion;
        end else if (r_nc != '0 && c_ab != '0) begin
            if (c_ab > 4'(r_nc)) begin
                if (r_na != '0 && r_nb != '0) begin
                    if (r_na != r_nb) begin
                        c_write   = 1'b1;
                        c_fill_op = r_pick ? OP_B : OP_A;
                    end else begin
                        c_tie_inc = 1'b1;
                    end
                end else begin
                    c_write   = 1'b1;
                    c_fill_op = (r_na == '0) ? OP_B : OP_A;
                end
            end else begin
                c_write   = 1'b1;
                c_fill_op = OP_C;
            end
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = c_cells[r_idx];
        ram_wdata = r_fill_op;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = OP_C;
        end else if (r_state == S_WR) begin
            ram_we = 1'b1;
        end
    end

    cmg_ram #(
        .WIDTH (OP_W),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (c_cells[r_idx]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_tot_a     <= '0;
            r_tot_b     <= '0;
            r_tot_c     <= TW'(CELLS);
            r_ties      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= (r_state == S_RD);
            if (r_pend) begin
                case (ram_rdata)
                    OP_A:    r_na <= r_na + 3'd1;
                    OP_B:    r_nb <= r_nb + 3'd1;
                    default: r_nc <= r_nc + 3'd1;
                endcase
            end

            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (c_accept) begin
                        r_action  <= i_action;
                        r_k       <= AW'(i_cell_index);
                        r_opinion <= i_opinion;
                        r_pick    <= i_tie_choice;
                        r_na      <= '0;
                        r_nb      <= '0;
                        r_nc      <= '0;
                        r_idx     <= '0;
                        if (!c_in_range || (i_action == ACT_LOAD && i_opinion > OP_B)) begin
                            r_state <= S_FIN;
                        end else if (i_action == ACT_LOAD) begin
                            r_last  <= 3'd0;
                            r_state <= S_RD;
                        end else begin
                            r_last  <= 3'd4;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= PW'(r_k) * PW'(RECIP);
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_row   <= c_row;
                    r_col   <= RW'(r_k - AW'(c_row * SIDE));
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_idx == r_last) begin
                        r_idx   <= '0;
                        r_state <= S_LAST;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                S_LAST: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_fill_op <= c_fill_op;
                    if (c_write) begin
                        r_tot_a <= r_tot_a - TW'(r_na) + ((c_fill_op == OP_A) ? c_nfill : '0);
                        r_tot_b <= r_tot_b - TW'(r_nb) + ((c_fill_op == OP_B) ? c_nfill : '0);
                        r_tot_c <= r_tot_c - TW'(r_nc) + ((c_fill_op == OP_C) ? c_nfill : '0);
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_FIN;
                    end
                    if (c_tie_inc && r_ties != '1) begin
                        r_ties <= r_ties + TIE_BITS'(1);
                    end
                end
                S_WR: begin
                    if (r_idx == r_last) begin
                        r_idx   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                S_FIN: begin
                    // Hold here until the output register is free
                    if (c_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_a       <= CNT_W'(r_tot_a);
                        r_out_b       <= CNT_W'(r_tot_b);
                        r_out_c       <= CNT_W'(r_tot_c);
                        r_out_ties    <= TIE_OUT_W'(r_ties);
                        r_out_settled <= (r_tot_c == '0) || (r_tot_c == TW'(CELLS));
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_count_a   = r_out_a;
    assign o_count_b   = r_out_b;
    assign o_count_c   = r_out_c;
    assign o_tie_count = r_out_ties;
    assign o_settled   = r_out_settled;

endmodule

// ===== hw/rtl/cmg_checker.sv =====
// Port-level checks for the coalition majority grid block, bound to the top level.
module cmg_checker #(
    parameter int SIDE = cmg_pkg::SIDE_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [cmg_pkg::CNT_W-1:0]     o_count_a,
    input logic [cmg_pkg::CNT_W-1:0]     o_count_b,
    input logic [cmg_pkg::CNT_W-1:0]     o_count_c,
    input logic [cmg_pkg::TIE_OUT_W-1:0] o_tie_count,
    input logic                          o_settled
);

    import cmg_pkg::*;

    localparam int CELLS = SIDE * SIDE;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_count_a)
            && $stable(o_count_b) && $stable(o_count_c) && $stable(o_tie_count)
            && $stable(o_settled))
        else $error("result changed while stalled");

    // One item at a time: ready drops after each accepted transaction
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready held after a transaction");

    // The three totals of every valid result account for every cell
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> CNT_W'(o_count_a + o_count_b + o_count_c) == CNT_W'(CELLS))
        else $error("opinion totals do not sum to the grid size");

    // Settled means no C at all, or nothing but C
    a_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_settled |-> o_count_c == '0
            || (o_count_a == '0 && o_count_b == '0))
        else $error("settled flag disagrees with totals");

endmodule

bind coalition_majority_grid_update cmg_checker #(
    .SIDE (SIDE)
) u_cmg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_count_a   (o_count_a),
    .o_count_b   (o_count_b),
    .o_count_c   (o_count_c),
    .o_tie_count (o_tie_count),
    .o_settled   (o_settled)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the coalition majority grid block.
module testbench;
    import cmg_pkg::*;

    localparam int SIDE        = SIDE_DEF;
    localparam int TIE_BITS    = TIE_BITS_DEF;
    localparam int CELLS       = SIDE * SIDE;
    localparam longint unsigned TIE_MAX =
        (TIE_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << TIE_BITS) - 64'd1);
    localparam logic [OP_W-1:0] OP_BAD = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int IDLE_LIMIT  = 4 * CELLS + 4 * HOLD_CYCLES;

    typedef struct packed {
        logic [CNT_W-1:0]     count_a;
        logic [CNT_W-1:0]     count_b;
        logic [CNT_W-1:0]     count_c;
        logic [TIE_OUT_W-1:0] tie_count;
        logic                 settled;
    } t_tally;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 i_action     = ACT_LOAD;
    logic [IDX_W-1:0]     i_cell_index = '0;
    logic [OP_W-1:0]      i_opinion    = OP_C;
    logic                 i_tie_choice = 1'b0;
    logic                 i_out_ready  = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [CNT_W-1:0]     o_count_a;
    logic [CNT_W-1:0]     o_count_b;
    logic [CNT_W-1:0]     o_count_c;
    logic [TIE_OUT_W-1:0] o_tie_count;
    logic                 o_settled;

    // Mirror of the grid and its totals
    logic [OP_W-1:0] grid_op [CELLS];
    int unsigned     tot_a = 0;
    int unsigned     tot_b = 0;
    int unsigned     tot_c = CELLS;
    longint unsigned tie_n = 0;

    t_tally expected_tallies [$];

    bit src_idle  = 1'b0;
    bit sink_idle = 1'b0;
    bit hold_req  = 1'b0;
    int n_errors     = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_rewrites   = 0;
    int n_tie_hits   = 0;
    int n_ignored    = 0;
    int quiet_cycles = 0;

    coalition_majority_grid_update uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_cell_index (i_cell_index),
        .i_opinion    (i_opinion),
        .i_tie_choice (i_tie_choice),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_count_a    (o_count_a),
        .o_count_b    (o_count_b),
        .o_count_c    (o_count_c),
        .o_tie_count  (o_tie_count),
        .o_settled    (o_settled)
    );

    always #5 i_clk = ~i_clk;

    initial begin : grid_clear
        for (int k = 0; k < CELLS; k++) grid_op[k] = OP_C;
    end

    // Slot 0 is the cell itself, then up, right, down, left with wrap-around.
    function automatic int unsigned cross_cell(int unsigned k, int slot);
        int unsigned row, col;
        row = k / SIDE;
        col = k % SIDE;
        case (slot)
            1: return ((row + SIDE - 1) % SIDE) * SIDE + col;
            2: return row * SIDE + (col + 1) % SIDE;
            3: return ((row + 1) % SIDE) * SIDE + col;
            4: return row * SIDE + (col + SIDE - 1) % SIDE;
            default: return k;
        endcase
    endfunction

    function automatic void recount(logic [OP_W-1:0] op, int delta);
        case (op)
            OP_A:    tot_a += delta;
            OP_B:    tot_b += delta;
            default: tot_c += delta;
        endcase
    endfunction

    function automatic t_tally predict_tally(logic act, logic [IDX_W-1:0] idx,
                                             logic [OP_W-1:0] op, logic pick);
        int na, nb, nc, i;
        int unsigned nbr;
        logic [OP_W-1:0] fill;
        logic do_fill;
        t_tally t;
        do_fill = 1'b0;
        fill    = OP_C;
        if (idx >= CELLS) begin
            n_ignored++;
        end else if (act == ACT_LOAD) begin
            if (op <= OP_B) begin
                recount(grid_op[idx], -1);
                grid_op[idx] = op;
                recount(op, 1);
            end else begin
                n_ignored++;
            end
        end else begin
            na = 0;
            nb = 0;
            nc = 0;
            for (i = 0; i < 5; i++) begin
                case (grid_op[cross_cell(32'(idx), i)])
                    OP_A:    na++;
                    OP_B:    nb++;
                    default: nc++;
                endcase
            end
            // Rule applies only when C meets A or B
            if (nc != 0 && (na != 0 || nb != 0)) begin
                if (na + nb > nc) begin
                    if (na > 0 && nb > 0) begin
                        if (na != nb) begin
                            do_fill = 1'b1;
                            fill    = pick ? OP_B : OP_A;
                        end else begin
                            n_tie_hits++;
                            if (tie_n < TIE_MAX) tie_n++;
                        end
                    end else begin
                        do_fill = 1'b1;
                        fill    = (na == 0) ? OP_B : OP_A;
                    end
                end else begin
                    do_fill = 1'b1;
                    fill    = OP_C;
                end
            end
            if (do_fill) begin
                n_rewrites++;
                for (i = 0; i < 5; i++) begin
                    nbr = cross_cell(32'(idx), i);
                    recount(grid_op[nbr], -1);
                    grid_op[nbr] = fill;
                    recount(fill, 1);
                end
            end
        end
        t.count_a   = tot_a[CNT_W-1:0];
        t.count_b   = tot_b[CNT_W-1:0];
        t.count_c   = tot_c[CNT_W-1:0];
        t.tie_count = tie_n[TIE_OUT_W-1:0];
        t.settled   = (tot_c == 0 || tot_c == CELLS);
        return t;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance with valid held.
    task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [OP_W-1:0] op, input logic pick);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_cell_index <= idx;
        i_opinion    <= op;
        i_tie_choice <= pick;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        expected_tallies.push_back(predict_tally(act, idx, op, pick));
        n_sent++;
        @(negedge i_clk);
    endtask

    // Pick a cell close to one of the corners or the centre, so neighbourhoods overlap.
    function automatic int unsigned near_hot();
        int unsigned base, row, col;
        case ($urandom_range(0, 4))
            0:       base = 0;
            1:       base = SIDE - 1;
            2:       base = CELLS - SIDE;
            3:       base = CELLS - 1;
            default: base = CELLS / 2 + SIDE / 2;
        endcase
        row = (base / SIDE + SIDE - 3 + $urandom_range(0, 6)) % SIDE;
        col = (base % SIDE + SIDE - 3 + $urandom_range(0, 6)) % SIDE;
        return row * SIDE + col;
    endfunction

    // Seed a neighbourhood with loads, then run updates inside it.
    task automatic send_cluster();
        int unsigned centre;
        int j, loads, steps;
        centre = near_hot();
        loads  = $urandom_range(0, 5);
        steps  = $urandom_range(1, 3);
        for (j = 0; j < loads; j++)
            send_item(ACT_LOAD, IDX_W'(cross_cell(centre, $urandom_range(0, 4))),
                      ($urandom_range(0, 9) == 0) ? OP_BAD : 2'($urandom_range(0, 2)),
                      1'($urandom_range(0, 1)));
        for (j = 0; j < steps; j++)
            send_item(ACT_UPDATE, IDX_W'(cross_cell(centre, $urandom_range(0, 4))),
                      2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_tally want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_tallies.size() == 0) begin
                n_errors++;
                $display("%0t: result with no transaction outstanding, expected none actual %0d/%0d/%0d",
                         $time, o_count_a, o_count_b, o_count_c);
            end else begin
                want = expected_tallies.pop_front();
                n_checked++;
                check_field("count_a", 32'(want.count_a), 32'(o_count_a));
                check_field("count_b", 32'(want.count_b), 32'(o_count_b));
                check_field("count_c", 32'(want.count_c), 32'(o_count_c));
                check_field("tie_count", want.tie_count, o_tie_count);
                check_field("settled", 32'(want.settled), 32'(o_settled));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAIL coalition_majority_grid_update");
            $finish;
        end
    end

    initial begin : sink_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(0, 17);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        int unsigned k;
        k = CELLS / 2 + SIDE / 2;
        sink_idle = 1'b1;
        send_item(ACT_LOAD, IDX_W'(0), OP_A, 1'b1);
        send_item(ACT_LOAD, IDX_W'(CELLS - 1), OP_B, 1'b0);
        send_item(ACT_LOAD, IDX_W'(CELLS - 1), OP_BAD, 1'b1);
        // Lone A among C at the corner: C wins across the wrap
        send_item(ACT_UPDATE, IDX_W'(0), OP_BAD, 1'b1);
        // Two A, one B, two C: the tie bit picks B
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 0)), OP_A, 1'b0);
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 1)), OP_A, 1'b0);
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 2)), OP_B, 1'b0);
        send_item(ACT_UPDATE, IDX_W'(k), OP_C, 1'b1);
        // B alone against C
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 3)), OP_C, 1'b1);
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 4)), OP_C, 1'b1);
        send_item(ACT_UPDATE, IDX_W'(k), OP_A, 1'b0);
        // Coalition again, tie bit picks A
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 0)), OP_A, 1'b0);
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 1)), OP_A, 1'b0);
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 2)), OP_C, 1'b0);
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 3)), OP_C, 1'b0);
        send_item(ACT_UPDATE, IDX_W'(k), OP_B, 1'b0);
        // A alone against C
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 3)), OP_C, 1'b0);
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 4)), OP_C, 1'b0);
        send_item(ACT_UPDATE, IDX_W'(k), OP_C, 1'b1);
        // Equal A and B outnumbering C: count a tie, rewrite nothing
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 1)), OP_B, 1'b0);
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 2)), OP_B, 1'b0);
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 4)), OP_C, 1'b0);
        send_item(ACT_UPDATE, IDX_W'(k), OP_A, 1'b0);
        send_item(ACT_UPDATE, IDX_W'(k), OP_A, 1'b1);
        // No C present, then no A or B present: both leave the grid alone
        send_item(ACT_LOAD, IDX_W'(cross_cell(k, 4)), OP_A, 1'b0);
        send_item(ACT_UPDATE, IDX_W'(k), OP_C, 1'b1);
        send_item(ACT_UPDATE, IDX_W'(CELLS / 4), OP_B, 1'b0);
    endtask

    // Load C over every cell that holds A or B, bringing settled back up.
    task automatic test_settle();
        int unsigned stale [$];
        for (int k = 0; k < CELLS; k++)
            if (grid_op[k] != OP_C) stale.push_back(k);
        foreach (stale[i])
            send_item(ACT_LOAD, IDX_W'(stale[i]), OP_C, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_backpressure();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        hold_req  = 1'b1;
        repeat (4) send_cluster();
    endtask

    task automatic test_drain_pause();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        repeat (3) send_cluster();
        i_in_valid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        repeat (3) send_cluster();
    endtask

    task automatic test_random_mix(int n_items);
        int stop_at;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            // Vary idling in stretches, some with none at all
            if ($urandom_range(0, 7) == 0) begin
                src_idle  = 1'($urandom_range(0, 1));
                sink_idle = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 9) < 7)
                send_cluster();
            else
                send_item(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, CELLS - 1)),
                          2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : run
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_settle();
        test_backpressure();
        test_drain_pause();
        test_random_mix(1100);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        test_settle();
        i_in_valid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d transactions, checked %0d results: %0d neighbourhood rewrites,",
                 n_sent, n_checked, n_rewrites);
        $display("%0d equal A/B ties, %0d ignored items, %0d mismatches",
                 n_tie_hits, n_ignored, n_errors);
        if (n_errors == 0) begin
            $display("PASS coalition_majority_grid_update");
        end else begin
            $display("FAIL coalition_majority_grid_update");
        end
        $finish;
    end

endmodule
